>>> hw/rtl/modexp_pkg.sv
package modexp_pkg;

   localparam int OPND_BITS = 31;
   localparam int CNT_BITS  = $clog2(OPND_BITS);

   typedef logic [OPND_BITS-1:0] opnd_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL_ACC,
      ST_MUL_SQ
   } state_type;

   localparam cnt_type  CNT_LAST = cnt_type'(OPND_BITS - 1);
   localparam opnd_type OPND_ONE = opnd_type'(1);

endpackage

>>> hw/rtl/modular_exponentiation.sv
// Modular exponentiation: residue = base_value ** power mod divisor.
//
// Input channel: a transaction is taken at a rising edge where start is high
// and busy is low. busy stays high while one transaction is in progress; the
// block works on one transaction at a time.
// Result channel: rsp_valid is high for exactly one cycle with rsp_residue.
// The receiver cannot stall, so the result is simply presented and dropped.
//
// Timing: all arithmetic is bit serial, one bit of a 31-bit operand per cycle
// through a single shift-and-add modular multiplier. The base is first
// reduced by the modulus; then each exponent bit costs one modular multiply
// into the accumulator if the bit is set and one squaring, and no squaring
// follows the highest set bit.
// A modulus of one or zero, or a zero exponent, is answered directly from idle.
// Reset (synchronous, active high) returns the sequencer to idle at once;
// a transaction in progress is abandoned without a result.
module modular_exponentiation (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  modexp_pkg::opnd_type req_base_value,
   input  modexp_pkg::opnd_type req_power,
   input  modexp_pkg::opnd_type req_divisor,
   output logic                 rsp_valid,
   output modexp_pkg::opnd_type rsp_residue
);
   import modexp_pkg::*;

   state_type state_ff, state_in;
   opnd_type  m_ff, m_in;
   opnd_type  e_ff, e_in;
   opnd_type  acc_ff, acc_in;
   opnd_type  sq_ff, sq_in;
   opnd_type  mul_a_ff, mul_a_in;
   opnd_type  mul_b_ff, mul_b_in;
   opnd_type  p_ff, p_in;
   cnt_type   cnt_ff, cnt_in;
   logic      rsp_valid_ff, rsp_valid_in;
   opnd_type  rsp_residue_ff, rsp_residue_in;

   // One step of the serial datapath: double the partial value, shift in the
   // next base bit when reducing, reduce, then add the multiplicand when the
   // multiplier bit is set and reduce again.
   logic [OPND_BITS:0] dbl;
   logic [OPND_BITS:0] sum;
   opnd_type           dbl_red;
   opnd_type           step_res;
   logic               reducing;
   logic               top_bit;

   assign reducing = (state_ff == ST_REDUCE);
   assign top_bit  = mul_b_ff[OPND_BITS-1];

   always_comb begin
      dbl      = {p_ff, reducing & top_bit};
      dbl_red  = (dbl >= {1'b0, m_ff}) ? opnd_type'(dbl - {1'b0, m_ff})
                                       : opnd_type'(dbl);
      sum      = {1'b0, dbl_red} + ((!reducing && top_bit) ? {1'b0, mul_a_ff}
                                                           : '0);
      step_res = (sum >= {1'b0, m_ff}) ? opnd_type'(sum - {1'b0, m_ff})
                                       : opnd_type'(sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff           <= m_in;
      e_ff           <= e_in;
      acc_ff         <= acc_in;
      sq_ff          <= sq_in;
      mul_a_ff       <= mul_a_in;
      mul_b_ff       <= mul_b_in;
      p_ff           <= p_in;
      cnt_ff         <= cnt_in;
      rsp_residue_ff <= rsp_residue_in;
   end

   always_comb begin
      logic     last;
      logic     e_bit;
      opnd_type sq_val;
      opnd_type e_next;

      state_in       = state_ff;
      m_in           = m_ff;
      e_in           = e_ff;
      acc_in         = acc_ff;
      sq_in          = sq_ff;
      mul_a_in       = mul_a_ff;
      mul_b_in       = {mul_b_ff[OPND_BITS-2:0], 1'b0};
      p_in           = step_res;
      cnt_in         = cnt_ff - cnt_type'(1);
      rsp_valid_in   = 1'b0;
      rsp_residue_in = rsp_residue_ff;

      last   = (cnt_ff == '0);
      e_bit  = e_ff[0];
      sq_val = sq_ff;
      e_next = e_ff >> 1;

      case (state_ff)
         ST_IDLE: begin
            p_in   = '0;
            cnt_in = CNT_LAST;
            if (start) begin
               m_in     = req_divisor;
               e_in     = req_power;
               acc_in   = OPND_ONE;
               mul_b_in = req_base_value;
               if (req_divisor <= OPND_ONE) begin
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = '0;
               end else if (req_power == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = OPND_ONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (last) begin
               sq_in  = step_res;
               sq_val = step_res;
               e_bit  = e_ff[0];
            end
         end
         ST_MUL_ACC: begin
            if (last) begin
               acc_in = step_res;
               if (e_next == '0) begin
                  state_in       = ST_IDLE;
                  rsp_valid_in   = 1'b1;
                  rsp_residue_in = step_res;
               end else begin
                  state_in = ST_MUL_SQ;
                  mul_a_in = sq_ff;
                  mul_b_in = sq_ff;
                  p_in     = '0;
                  cnt_in   = CNT_LAST;
               end
            end
         end
         ST_MUL_SQ: begin
            if (last) begin
               sq_in  = step_res;
               sq_val = step_res;
               e_in   = e_next;
               e_bit  = e_next[0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Start the work for the next exponent bit once the square is ready.
      if (last && (state_ff == ST_REDUCE || state_ff == ST_MUL_SQ)) begin
         p_in   = '0;
         cnt_in = CNT_LAST;
         if (e_bit) begin
            state_in = ST_MUL_ACC;
            mul_a_in = acc_ff;
            mul_b_in = sq_val;
         end else begin
            state_in = ST_MUL_SQ;
            mul_a_in = sq_val;
            mul_b_in = sq_val;
         end
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import modexp_pkg::*;

   localparam int       RESET_CYCLES = 8;
   localparam int       RANDOM_ITEMS = 270;
   localparam int       DRAIN_CYCLES = 2048;
   localparam int       CYCLE_LIMIT  = 3_000_000;
   localparam opnd_type OPND_MAX     = '1;

   class residue_scoreboard;
      opnd_type pending_residues[$];
      int       failures = 0;

      // Shift-and-add product; with a below m no partial sum reaches 2m.
      function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
         logic [63:0] acc;
         acc = '0;
         for (int i = OPND_BITS - 1; i >= 0; i--) begin
            acc = acc + acc;
            if (acc >= m) acc -= m;
            if (b[i]) begin
               acc += a;
               if (acc >= m) acc -= m;
            end
         end
         return acc;
      endfunction

      function opnd_type power_mod(opnd_type base_value, opnd_type power, opnd_type divisor);
         logic [63:0] acc;
         logic [63:0] square;
         logic [63:0] modulus;
         if (divisor <= OPND_ONE) return '0;
         modulus = 64'(divisor);
         acc     = 64'd1;
         square  = 64'(base_value) % modulus;
         for (int i = 0; i < OPND_BITS; i++) begin
            if (power[i]) acc = mul_mod(acc, square, modulus);
            square = mul_mod(square, square, modulus);
         end
         return opnd_type'(acc);
      endfunction

      function void note_request(opnd_type base_value, opnd_type power, opnd_type divisor);
         pending_residues.push_back(power_mod(base_value, power, divisor));
      endfunction

      function void check_residue(opnd_type actual);
         opnd_type expected;
         if (pending_residues.size() == 0) begin
            $error("residue: no transaction outstanding, actual %0d", actual);
            failures++;
            return;
         end
         expected = pending_residues.pop_front();
         if (actual !== expected) begin
            $error("residue: expected %0d, actual %0d", expected, actual);
            failures++;
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset;
   logic     start;
   logic     busy;
   opnd_type req_base_value;
   opnd_type req_power;
   opnd_type req_divisor;
   logic     rsp_valid;
   opnd_type rsp_residue;

   residue_scoreboard board = new();
   int                idle_percent = 16;
   int                cycle_count  = 0;

   modular_exponentiation i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_base_value (req_base_value),
      .req_power      (req_power),
      .req_divisor    (req_divisor),
      .rsp_valid      (rsp_valid),
      .rsp_residue    (rsp_residue)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req_base_value, req_power, req_divisor);
         if (rsp_valid) board.check_residue(rsp_residue);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction is taken.
   task automatic send_request(opnd_type base_value, opnd_type power, opnd_type divisor);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_base_value <= base_value;
      req_power      <= power;
      req_divisor    <= divisor;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic opnd_type random_operand();
      case ($urandom_range(5))
         0:       return opnd_type'($urandom_range(15));
         1:       return opnd_type'($urandom_range(255));
         2:       return OPND_MAX - opnd_type'($urandom_range(15));
         3:       return OPND_ONE << $urandom_range(OPND_BITS - 1);
         default: return opnd_type'($urandom());
      endcase
   endfunction

   function automatic opnd_type random_divisor();
      opnd_type divisor;
      divisor = random_operand();
      if (divisor == '0) divisor = OPND_ONE;
      return divisor;
   endfunction

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_base_value = '0;
      req_power      = '0;
      req_divisor    = OPND_ONE;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero base, zero exponent, unit modulus and the operand extremes.
      send_request(0, 0, 5);
      send_request(0, 7, 5);
      send_request(123, 456, 1);
      send_request(OPND_MAX, OPND_MAX, 1);
      send_request(OPND_MAX, 0, OPND_MAX);
      send_request(5, 0, 2);
      send_request(OPND_MAX, OPND_MAX, OPND_MAX);
      send_request(OPND_MAX - 1, OPND_MAX, OPND_MAX);
      send_request(2, OPND_MAX, OPND_MAX);
      send_request(OPND_MAX, OPND_MAX, OPND_MAX - 1);
      send_request(3, 1, 7);
      send_request(10, 1, 7);
      send_request(1, OPND_MAX, 97);
      send_request(2, OPND_ONE << (OPND_BITS - 1), 1000003);
      send_request(7, 2, 2);
      send_request(12345, 65537, OPND_MAX - 1);
      send_request(OPND_MAX, 1, 2);
      send_request(4, 13, 497);
      send_request(2, 10, 1024);
      send_request(OPND_MAX, 2, OPND_ONE << (OPND_BITS - 1));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // A stretch of back-to-back transactions in the middle of the run.
         idle_percent = (n >= 90 && n < 150) ? 0 : 16;
         send_request(random_operand(), random_operand(), random_divisor());
      end
      start <= 1'b0;

      while (board.pending_residues.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending_residues.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/modexp_pkg.sv
hw/rtl/modular_exponentiation.sv
sim/testbench.sv
